@@ rtl/core/afe_pkg.sv @@
// package for the average fuel economy block: beat structs, command codes,
// constants and the sequencer state type; no dependencies
package afe_pkg;

    // field widths
    localparam int FUEL_W   = 32;
    localparam int DIST_W   = 32;
    localparam int ECO_W    = 8;
    localparam int LITRE_W  = 13;
    localparam int KM_W     = 29;
    localparam int RPM_W    = 16;
    localparam int CMD_W    = 2;

    // serial divider sizing
    localparam int Q_W      = 32;
    localparam int DIV_W    = 40;
    localparam int STEP_W   = $clog2(Q_W);

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

    // constants
    localparam logic [RPM_W-1:0] RPM_THRESHOLD  = 16'd300;
    localparam logic [1:0]       RPM_SAT        = 2'd3;
    localparam logic [2:0]       REFRESH_LAST   = 3'd5;
    localparam logic [DIV_W-1:0] UL_PER_LITRE   = 40'd1000000;
    localparam logic [DIV_W-1:0] KM_DIVISOR     = 40'd10;
    localparam logic [Q_W-1:0]   LITRE_LIMIT    = 32'd200;
    localparam logic [Q_W-1:0]   KM_LIMIT       = 32'd2000;
    localparam logic [ECO_W-1:0] ECONOMY_MAX    = 8'd199;
    localparam logic [FUEL_W-1:0] CLEAR_FUEL    = 32'd750000;
    localparam logic [DIST_W-1:0] CLEAR_DIST    = 32'd100;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              ign_on;
        logic [RPM_W-1:0]  engine_rpm;
        logic [FUEL_W-1:0] fuel_amount;
        logic [DIST_W-1:0] distance_amount;
    } in_beat_t;

    typedef struct packed {
        logic [ECO_W-1:0]   economy;
        logic [LITRE_W-1:0] fuel_litres;
        logic [KM_W-1:0]    distance_km;
        logic [FUEL_W-1:0]  fuel_total_now;
        logic [DIST_W-1:0]  distance_total_now;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_MUL,
        ST_ECO_GO,
        ST_ECO_WAIT,
        ST_DONE
    } state_t;

endpackage

@@ rtl/core/afe_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// depends on afe_pkg
module afe_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [afe_pkg::Q_W-1:0]    dividend,
    input  logic [afe_pkg::DIV_W-1:0]  divisor,
    output logic                       done,
    output logic [afe_pkg::Q_W-1:0]    quotient
);
    import afe_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(Q_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [Q_W-1:0]    rq_reg, rq_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dsr_reg, dsr_next;
    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;

    // one trial subtract per cycle; dividend bits shift out as quotient bits shift in
    always_comb begin
        shifted   = {rem_reg, rq_reg[Q_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rq_next   = rq_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rq_next   = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[DIV_W]) begin
                rem_next = diff[DIV_W-1:0];
                rq_next  = {rq_reg[Q_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_W-1:0];
                rq_next  = {rq_reg[Q_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge aclk) begin
        rq_reg  <= rq_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = rq_reg;

endmodule

@@ rtl/core/average_fuel_economy_top.sv @@
// clear, unused command codes and ticks with ignition off go straight to the result;
// a tick runs a litres and kilometres divide, a load an economy divide, and a tick
// that refreshes the economy runs both (each divide is a serial divider pass).
// one beat at a time: the next beat can be taken in the cycle after the result loads.
// synchronous active-low reset clears all totals and counters; needs afe_pkg, afe_div
module average_fuel_economy_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  afe_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output afe_pkg::out_beat_t m_data
);
    import afe_pkg::*;

    state_t             state_reg, state_next;
    logic [FUEL_W-1:0]  fuel_total_reg;
    logic [DIST_W-1:0]  dist_total_reg;
    logic [FUEL_W-1:0]  backup_reg;
    logic [ECO_W-1:0]   economy_reg;
    logic [LITRE_W-1:0] litres_reg;
    logic [KM_W-1:0]    km_reg;
    logic [1:0]         rpm_sec_reg;
    logic [2:0]         refresh_reg;
    logic [DIV_W-1:0]   eco_dsr_reg;
    logic               m_valid_reg;
    out_beat_t          m_data_reg;

    logic [FUEL_W-1:0]  fuel_sum;
    logic [DIST_W-1:0]  dist_sum;
    logic [1:0]         rpm_sec_new;
    logic [DIV_W-1:0]   dist_ext;
    logic               div_start;
    logic [DIV_W-1:0]   fdiv_divisor;
    logic               fdiv_done;
    logic               ddiv_done;
    logic [Q_W-1:0]     q_fuel;
    logic [Q_W-1:0]     q_dist;
    logic               out_load;
    logic               halve;

    // fuel divider: litres, then economy
    afe_div u_fdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (fuel_total_reg),
        .divisor  (fdiv_divisor),
        .done     (fdiv_done),
        .quotient (q_fuel)
    );

    // distance divider: kilometres
    afe_div u_ddiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start && (state_reg == ST_DIV1_GO)),
        .dividend (dist_total_reg),
        .divisor  (KM_DIVISOR),
        .done     (ddiv_done),
        .quotient (q_dist)
    );

    // tick arithmetic
    always_comb begin
        fuel_sum = fuel_total_reg + s_data.fuel_amount;
        dist_sum = dist_total_reg + s_data.distance_amount;
        if (s_data.engine_rpm >= RPM_THRESHOLD) begin
            rpm_sec_new = (rpm_sec_reg == RPM_SAT) ? RPM_SAT : rpm_sec_reg + 2'd1;
        end else begin
            rpm_sec_new = 2'd0;
        end
        dist_ext = {{(DIV_W-DIST_W){1'b0}}, dist_total_reg};
        halve    = (q_fuel >= LITRE_LIMIT) || (q_dist >= KM_LIMIT);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.cmd)
                        CMD_TICK:  state_next = s_data.ign_on ? ST_DIV1_GO : ST_DONE;
                        CMD_LOAD:  state_next = ST_MUL;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_DIV1_GO:   state_next = ST_DIV1_WAIT;
            ST_DIV1_WAIT: begin
                if (fdiv_done && ddiv_done) begin
                    if (dist_total_reg == '0) begin
                        state_next = ST_DONE;
                    end else if (refresh_reg >= REFRESH_LAST) begin
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL:       state_next = ST_ECO_GO;
            ST_ECO_GO:    state_next = ST_ECO_WAIT;
            ST_ECO_WAIT:  if (fdiv_done) state_next = ST_DONE;
            ST_DONE:      if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        div_start    = (state_reg == ST_DIV1_GO) || (state_reg == ST_ECO_GO);
        fdiv_divisor = (state_reg == ST_ECO_GO) ? eco_dsr_reg : UL_PER_LITRE;
        out_load     = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // totals, readouts and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fuel_total_reg <= '0;
            dist_total_reg <= '0;
            backup_reg     <= '0;
            economy_reg    <= '0;
            litres_reg     <= '0;
            km_reg         <= '0;
            rpm_sec_reg    <= '0;
            refresh_reg    <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        case (s_data.cmd)
                            CMD_TICK: begin
                                dist_total_reg <= dist_sum;
                                if (s_data.ign_on) begin
                                    rpm_sec_reg <= rpm_sec_new;
                                    if (rpm_sec_new == RPM_SAT) begin
                                        backup_reg     <= fuel_sum;
                                        fuel_total_reg <= fuel_sum;
                                    end else begin
                                        fuel_total_reg <= backup_reg;
                                    end
                                end else begin
                                    fuel_total_reg <= fuel_sum;
                                    rpm_sec_reg    <= '0;
                                    refresh_reg    <= '0;
                                end
                            end
                            CMD_CLEAR: begin
                                fuel_total_reg <= CLEAR_FUEL;
                                dist_total_reg <= CLEAR_DIST;
                                backup_reg     <= CLEAR_FUEL;
                                economy_reg    <= '0;
                                litres_reg     <= '0;
                                km_reg         <= '0;
                                rpm_sec_reg    <= '0;
                                refresh_reg    <= '0;
                            end
                            CMD_LOAD: begin
                                fuel_total_reg <= s_data.fuel_amount;
                                dist_total_reg <= s_data.distance_amount;
                                backup_reg     <= s_data.fuel_amount;
                                rpm_sec_reg    <= '0;
                                refresh_reg    <= '0;
                            end
                            default: begin
                                refresh_reg <= refresh_reg;
                            end
                        endcase
                    end
                end
                ST_DIV1_WAIT: begin
                    if (fdiv_done && ddiv_done) begin
                        litres_reg <= q_fuel[LITRE_W-1:0];
                        km_reg     <= q_dist[KM_W-1:0];
                        if (dist_total_reg == '0) begin
                            economy_reg <= '0;
                        end else if (refresh_reg >= REFRESH_LAST) begin
                            refresh_reg <= '0;
                            if (halve) begin
                                fuel_total_reg <= fuel_total_reg >> 1;
                                dist_total_reg <= dist_total_reg >> 1;
                            end
                        end else begin
                            refresh_reg <= refresh_reg + 3'd1;
                        end
                    end
                end
                ST_ECO_WAIT: begin
                    // zero divisor yields an all-ones quotient, which caps the same way
                    if (fdiv_done) begin
                        economy_reg <= (q_fuel > Q_W'(ECONOMY_MAX)) ? ECONOMY_MAX
                                                                     : q_fuel[ECO_W-1:0];
                    end
                end
                default: begin
                    refresh_reg <= refresh_reg;
                end
            endcase
        end
    end

    // economy divisor: distance * 100 as shifts and adds
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL) begin
            eco_dsr_reg <= (dist_ext << 6) + (dist_ext << 5) + (dist_ext << 2);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.economy            <= economy_reg;
            m_data_reg.fuel_litres        <= litres_reg;
            m_data_reg.distance_km        <= km_reg;
            m_data_reg.fuel_total_now     <= fuel_total_reg;
            m_data_reg.distance_total_now <= dist_total_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/core/afe_checker.sv @@
// port-level checks for the average fuel economy block, bound to the top level
// depends on afe_pkg and average_fuel_economy_top
module afe_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input afe_pkg::in_beat_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input afe_pkg::out_beat_t m_data
);
    import afe_pkg::*;

    // a stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // one beat at a time: busy right after taking a beat
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while previous beat in work");

    // economy is capped
    a_eco_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.economy <= ECONOMY_MAX)
        else $error("economy above cap");

    // clear on an empty output reports the starting totals, via the done state and the output register
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.cmd == CMD_CLEAR) && !m_valid |=> ##1
        m_valid && (m_data.fuel_total_now == CLEAR_FUEL)
        && (m_data.distance_total_now == CLEAR_DIST) && (m_data.economy == '0))
        else $error("clear result wrong");

endmodule

bind average_fuel_economy_top afe_checker u_afe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
